// ===== design/spf_pkg.sv =====
// sensor packet framer package: constants, types, register indexes and crc-8 step
// no dependencies
`timescale 1ns / 1ps

package spf_pkg;

	localparam int FRAME_LEN = 12;
	localparam int CRC_LEN   = 11;
	localparam int IDX_W     = $clog2(FRAME_LEN);

	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(FRAME_LEN - 1);
	localparam logic [7:0] CRC_POLY      = 8'h07;
	localparam logic [7:0] CRC_INIT      = 8'h00;
	localparam logic [7:0] RST_VERSION   = 8'd3;
	localparam logic [7:0] RST_SENSOR_ID = 8'd1;
	localparam logic [7:0] RST_XOR_KEY   = 8'h5A;

	typedef enum logic [1:0] {
		REG_VERSION   = 2'd0,
		REG_SENSOR_ID = 2'd1,
		REG_XOR_KEY   = 2'd2
	} cfg_idx_t;

	typedef struct packed {
		logic [7:0] version;
		logic [7:0] sensor_id;
		logic [7:0] xor_key;
	} cfg_t;

	// bytes 0 to 10 of a packet, byte 0 in the low slot
	typedef logic [CRC_LEN-1:0][7:0] frame_t;

	function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] data);
		logic [7:0] r;
		r = crc ^ data;
		for (int k = 0; k < 8; k++) begin
			r = r[7] ? ((r << 1) ^ CRC_POLY) : (r << 1);
		end
		return r;
	endfunction

endpackage

// ===== design/spf_if.sv =====
// sensor packet framer channel interfaces: sample set input and packet byte output
// no dependencies
`timescale 1ns / 1ps

interface spf_sample_if;
	logic               valid;
	logic               ready;
	logic signed [15:0] temperature;
	logic        [15:0] pressure;
	logic        [15:0] humidity;
	logic        [15:0] fuel_level;
	logic        [6:0]  status;
	logic               obfuscate;

	modport source (output valid, temperature, pressure, humidity, fuel_level, status,
		obfuscate, input ready);
	modport sink (input valid, temperature, pressure, humidity, fuel_level, status,
		obfuscate, output ready);
endinterface

interface spf_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] packet_byte;
	logic       last_byte;

	modport source (output valid, packet_byte, last_byte, input ready);
	modport sink (input valid, packet_byte, last_byte, output ready);
endinterface

// ===== design/sensor_packet_framer_crc8_top.sv =====
// sensor packet framer top level: config registers, frame build, serializer
// depends on spf_pkg, spf_if, spf_cfg_regs, spf_frame_build, spf_serializer
//
// channel   dir  handshake     payload
// sample    in   valid/ready   temperature, pressure, humidity, fuel_level, status, obfuscate
// pkt       out  valid/ready   packet_byte, last_byte
// cfg       in   cfg_we        cfg_index, cfg_wdata
//
// one sample set gives 12 bytes, one per cycle while pkt.ready is high; the serializer sets the
// pace of the packets, with the crc built one byte per cycle as bytes leave
// on an idle block a sample set is registered in the input register, then in the serializer, before byte 0 is valid
// one further sample set waits in the input register while a packet is being sent
// reset sets version 3, sensor id 1, key 0x5A and drops all valids
// low pkt.ready holds the current byte; the input stalls once the input register is full
`timescale 1ns / 1ps

module sensor_packet_framer_crc8_top (
	input  logic         clk,
	input  logic         arst_n,
	spf_sample_if.sink   sample,
	spf_byte_if.source   pkt,
	input  logic         cfg_we,
	input  logic [1:0]   cfg_index,
	input  logic [7:0]   cfg_wdata
);
	import spf_pkg::*;

	cfg_t   cfg;
	logic   hold_valid;
	frame_t hold_frame;
	logic   take;

	spf_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	spf_frame_build u_build (
		.clk        (clk),
		.arst_n     (arst_n),
		.sample     (sample),
		.cfg        (cfg),
		.take       (take),
		.hold_valid (hold_valid),
		.hold_frame (hold_frame)
	);

	spf_serializer u_ser (
		.clk        (clk),
		.arst_n     (arst_n),
		.hold_valid (hold_valid),
		.hold_frame (hold_frame),
		.take       (take),
		.pkt        (pkt)
	);

	// a full input register only accepts when it is being emptied in the same cycle
	a_accept_needs_take: assert property (@(posedge clk) disable iff (!arst_n)
		(sample.valid && sample.ready && hold_valid) |-> take)
		else $error("input accepted over a held sample set");

	// bytes of one packet follow without a gap
	a_packet_continues: assert property (@(posedge clk) disable iff (!arst_n)
		(pkt.valid && pkt.ready && !pkt.last_byte) |=> pkt.valid)
		else $error("packet stopped before its crc byte");

	// the crc byte ends the packet unless another one is waiting
	a_packet_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(pkt.valid && pkt.ready && pkt.last_byte && !hold_valid) |=> !pkt.valid)
		else $error("output valid after the last byte with nothing held");

	// a waiting sample set moves to the serializer when it goes idle
	a_take_on_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(hold_valid && !pkt.valid) |-> take)
		else $error("held sample set not taken by an idle serializer");

endmodule

// ===== design/spf_cfg_regs.sv =====
// configuration registers: version, sensor id and xor key
// depends on spf_pkg
`timescale 1ns / 1ps

module spf_cfg_regs (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cfg_we,
	input  logic [1:0]    cfg_index,
	input  logic [7:0]    cfg_wdata,
	output spf_pkg::cfg_t cfg
);
	import spf_pkg::*;

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.version   <= RST_VERSION;
			cfg_q.sensor_id <= RST_SENSOR_ID;
			cfg_q.xor_key   <= RST_XOR_KEY;
		end else if (cfg_we) begin
			case (cfg_idx_t'(cfg_index))
				REG_VERSION:   cfg_q.version   <= cfg_wdata;
				REG_SENSOR_ID: cfg_q.sensor_id <= cfg_wdata;
				REG_XOR_KEY:   cfg_q.xor_key   <= cfg_wdata;
				default:       cfg_q           <= cfg_q;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// ===== design/spf_frame_build.sv =====
// packet assembly with optional xor, held in a one-entry input register
// depends on spf_pkg and spf_sample_if
`timescale 1ns / 1ps

module spf_frame_build (
	input  logic            clk,
	input  logic            arst_n,
	spf_sample_if.sink      sample,
	input  spf_pkg::cfg_t   cfg,
	input  logic            take,
	output logic            hold_valid,
	output spf_pkg::frame_t hold_frame
);
	import spf_pkg::*;

	logic       hold_valid_q;
	frame_t     hold_frame_q;
	frame_t     frame_d;
	logic [7:0] key;
	logic       accept;

	always_comb begin
		key         = sample.obfuscate ? cfg.xor_key : 8'h00;
		frame_d[0]  = cfg.version ^ key;
		frame_d[1]  = cfg.sensor_id ^ key;
		frame_d[2]  = sample.temperature[15:8] ^ key;
		frame_d[3]  = sample.temperature[7:0] ^ key;
		frame_d[4]  = sample.pressure[15:8] ^ key;
		frame_d[5]  = sample.pressure[7:0] ^ key;
		frame_d[6]  = sample.humidity[15:8] ^ key;
		frame_d[7]  = sample.humidity[7:0] ^ key;
		frame_d[8]  = sample.fuel_level[15:8] ^ key;
		frame_d[9]  = sample.fuel_level[7:0] ^ key;
		frame_d[10] = {sample.obfuscate, sample.status};
	end

	assign sample.ready = !hold_valid_q || take;
	assign accept       = sample.valid && sample.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_valid_q <= 1'b0;
		end else if (accept) begin
			hold_valid_q <= 1'b1;
		end else if (take) begin
			hold_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			hold_frame_q <= frame_d;
		end
	end

	assign hold_valid = hold_valid_q;
	assign hold_frame = hold_frame_q;

endmodule

// ===== design/spf_serializer.sv =====
// byte serializer with running crc-8, appends the crc as the last byte
// depends on spf_pkg and spf_byte_if
`timescale 1ns / 1ps

module spf_serializer (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            hold_valid,
	input  spf_pkg::frame_t hold_frame,
	output logic            take,
	spf_byte_if.source      pkt
);
	import spf_pkg::*;

	logic             busy_q;
	logic [IDX_W-1:0] idx_q;
	frame_t           frame_q;
	logic [7:0]       crc_q;
	logic             last;
	logic             fire;

	assign last = (idx_q == LAST_IDX);
	assign fire = busy_q && pkt.ready;
	assign take = hold_valid && (!busy_q || (fire && last));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			idx_q  <= '0;
		end else if (take) begin
			busy_q <= 1'b1;
			idx_q  <= '0;
		end else if (fire) begin
			busy_q <= !last;
			idx_q  <= last ? '0 : idx_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			frame_q <= hold_frame;
			crc_q   <= CRC_INIT;
		end else if (fire && !last) begin
			frame_q <= {8'h00, frame_q[CRC_LEN-1:1]};
			crc_q   <= crc8_byte(crc_q, frame_q[0]);
		end
	end

	assign pkt.valid       = busy_q;
	assign pkt.packet_byte = last ? crc_q : frame_q[0];
	assign pkt.last_byte   = last;

endmodule
